// ===== rtl/core/rbma_pkg.sv =====
// ----------------------------------------------------------------------------
// rbma_pkg - shared types and constants for the ring buffer moving average
// Default sizes, configuration width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rbma_pkg;

	// window register width as seen on the configuration port
	localparam int CFG_W = 7;

	// defaults for the top-level parameters
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DELTA = 6'b000010,
		ST_UPD   = 6'b000100,
		ST_PREP  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

endpackage

// ===== rtl/core/ring_buffer_moving_average.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_moving_average - simple moving average over a sample ring
// Running sum of the last N samples divided by the samples held, with a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one per transaction; every sample
//   yields exactly one average on the m_axis channel, in order. The average
//   is the running sum of the samples held divided by their count, truncated
//   toward zero. cfg_* writes the window length (0 acts as 1, values above
//   MAX_WINDOW saturate) and clears sum, fill count and write slot; write it
//   only while the block is idle. cfg_ready is high only while the sequencer
//   is idle, and s_axis_tready is held low while cfg_valid is high.
// Sequencing:
//   An accepted sample passes the DELTA, UPD, PREP, DIV and FIN states before
//   m_axis_tvalid rises; the divider yields one quotient bit per cycle, SUM_W
//   bits in all (SUM_W = SAMPLE_BITS + log2(MAX_WINDOW)). One sample is worked
//   on at a time: no new sample is taken until the sequencer is idle again.
// Reset:
//   arst_n clears sum, fill count, write slot and the output valid flag and
//   sets the window to MAX_WINDOW. The sample ring is not cleared: a slot's old
//   value is only used after the slot has been written since the last clear.
// Stall:
//   A finished average sits in the output register; the next sample is taken
//   meanwhile. If that next average is done while the register is still
//   full, the sequencer waits in its final state until m_axis_tready.
// ----------------------------------------------------------------------------
module ring_buffer_moving_average #(
	parameter int MAX_WINDOW  = rbma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = rbma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// window length register
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rbma_pkg::CFG_W-1:0]          cfg_data,

	// sample input
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] sample

	// average output
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata    // [SAMPLE_BITS-1:0] average
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IDX_W  = $clog2(MAX_WINDOW);          // ring address
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);      // fill count, window
	localparam int SUM_W  = SAMPLE_BITS + IDX_W;         // never overflows
	localparam int DLT_W  = SAMPLE_BITS + 1;             // new minus oldest
	localparam int BIT_W  = $clog2(SUM_W);               // divider step count

	rbma_pkg::state_t state_q;

	// configuration and running state
	logic [CNT_W-1:0]              win_q;    // effective window, 1..MAX_WINDOW
	logic [CNT_W-1:0]              fill_q;
	logic [IDX_W-1:0]              slot_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic                          full_q;

	// per-item payload
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;     // oldest sample, registered read
	logic signed [DLT_W-1:0]       delta_q;

	// divider
	logic [SUM_W-1:0]              dvd_q;    // dividend in, quotient out
	logic [CNT_W-1:0]              rem_q;
	logic [BIT_W-1:0]              bit_q;
	logic                          neg_q;

	// output register
	logic                          ovalid_q;
	logic [SAMPLE_BITS-1:0]        avg_q;

	logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];

	logic                          in_xact;
	logic                          out_xact;
	logic                          cfg_xact;
	logic                          out_free;
	logic [CNT_W-1:0]              win_new;
	logic [CNT_W-1:0]              slot_inc;
	logic [CNT_W:0]                rem_shift;
	logic [CNT_W:0]                rem_diff;
	logic                          q_bit;
	logic [SAMPLE_BITS-1:0]        quo;

	// window write wins over a sample offered in the same cycle
	assign cfg_ready     = (state_q == rbma_pkg::ST_IDLE);
	assign s_axis_tready = (state_q == rbma_pkg::ST_IDLE) && !cfg_valid;
	assign in_xact       = s_axis_tvalid & s_axis_tready;
	assign out_xact      = ovalid_q & m_axis_tready;
	assign cfg_xact      = cfg_valid & cfg_ready;
	assign out_free      = !ovalid_q || m_axis_tready;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = DATA_W'(avg_q);

	// clamp written window: zero acts as one, oversize saturates
	always_comb begin
		if (cfg_data == '0) begin
			win_new = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
			win_new = CNT_W'(MAX_WINDOW);
		end else begin
			win_new = CNT_W'(cfg_data);
		end
	end

	assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);

	// one restoring step per cycle
	assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, fill_q};
	assign q_bit     = !rem_diff[CNT_W];

	assign quo = dvd_q[SAMPLE_BITS-1:0];

	// sample ring: read-first, written on the accepting edge
	always_ff @(posedge clk) begin
		if (in_xact) begin
			rd_q             <= ring_mem[slot_q];
			ring_mem[slot_q] <= s_axis_tdata[SAMPLE_BITS-1:0];
			smp_q            <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (state_q)
			rbma_pkg::ST_DELTA: begin
				// oldest sample only leaves once the window is full
				delta_q <= DLT_W'(smp_q) - (full_q ? DLT_W'(rd_q) : DLT_W'(0));
			end
			rbma_pkg::ST_PREP: begin
				neg_q <= sum_q[SUM_W-1];
				dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
				rem_q <= '0;
			end
			rbma_pkg::ST_DIV: begin
				rem_q <= q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
				dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
			end
			rbma_pkg::ST_FIN: begin
				if (out_free) begin
					avg_q <= neg_q ? SAMPLE_BITS'(-quo) : quo;
				end
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rbma_pkg::ST_IDLE;
			win_q    <= CNT_W'(MAX_WINDOW);
			fill_q   <= '0;
			slot_q   <= '0;
			sum_q    <= '0;
			full_q   <= 1'b0;
			bit_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_xact) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				rbma_pkg::ST_IDLE: begin
					if (cfg_xact) begin
						win_q  <= win_new;
						fill_q <= '0;
						slot_q <= '0;
						sum_q  <= '0;
					end else if (in_xact) begin
						full_q <= (fill_q == win_q);
						if (fill_q != win_q) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						slot_q  <= (slot_inc >= win_q) ? '0 : slot_inc[IDX_W-1:0];
						state_q <= rbma_pkg::ST_DELTA;
					end
				end
				rbma_pkg::ST_DELTA: begin
					state_q <= rbma_pkg::ST_UPD;
				end
				rbma_pkg::ST_UPD: begin
					sum_q   <= sum_q + SUM_W'(delta_q);
					state_q <= rbma_pkg::ST_PREP;
				end
				rbma_pkg::ST_PREP: begin
					bit_q   <= BIT_W'(SUM_W - 1);
					state_q <= rbma_pkg::ST_DIV;
				end
				rbma_pkg::ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= rbma_pkg::ST_FIN;
					end
				end
				rbma_pkg::ST_FIN: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q  <= rbma_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rbma_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// fill count never runs past the window
	a_fill_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_q)
		else $error("fill count above window");

	// write slot stays inside the window
	a_slot_lt_win: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(slot_q) < win_q)
		else $error("write slot outside window");

	// divider remainder stays below the divisor
	a_rem_lt_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbma_pkg::ST_DIV) |-> (rem_q < fill_q))
		else $error("divider remainder not reduced");

	// a finished average is always handed to the output register
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbma_pkg::ST_FIN) && out_free |=> ovalid_q)
		else $error("average lost at output register");

	// an accepted sample blocks further input until its average is done
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !s_axis_tready)
		else $error("input accepted while busy");
`endif

endmodule
